### design/suffix_automaton_lcs_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SUFFIX_AUTOMATON_LCS_ASSERT_SVH
`define SUFFIX_AUTOMATON_LCS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sal_pkg.sv
`default_nettype none
package sal_pkg;

  localparam int MAX_TEXT   = 1024;
  localparam int NODES      = 2 * MAX_TEXT;
  localparam int NODE_W     = 11;
  localparam int CNT_W      = 12;
  localparam int LEN_W      = 11;
  localparam int TEXT_W     = 10;
  localparam int SYM_W      = 8;
  localparam int EPOCH_W    = 4;
  localparam int TR_ADDR_W  = NODE_W + SYM_W;
  localparam int TR_DATA_W  = EPOCH_W + NODE_W;
  localparam int ROW_CNT_W  = SYM_W + 1;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_A_RD,
    ST_A_EV,
    ST_A_LK,
    ST_A_LP,
    ST_A_LQ,
    ST_A_CMP,
    ST_A_CP,
    ST_A_CLR,
    ST_A_CLW,
    ST_A_RRD,
    ST_A_REV,
    ST_A_RLK,
    ST_A_FQ,
    ST_A_FC,
    ST_M_RD,
    ST_M_EV,
    ST_M_LK,
    ST_M_LN,
    ST_M_LW,
    ST_M_QRD,
    ST_M_QEV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [TEXT_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              overflow;
  } result_t;

endpackage
`default_nettype wire

### design/suffix_automaton_lcs.sv
`default_nettype none
// Suffix automaton longest-common-substring engine. Input transactions carry an opcode in
// in_tuser (clear, append text byte, match query byte), the byte in in_tdata and the
// end-of-query mark in in_tlast. One result transaction follows each query byte marked
// last. The block works on one transaction at a time through a single-port-per-side
// transition memory: an append visits suffix links, and when a node is cloned it copies
// the row of 256 entries and redirects links; a match byte follows suffix links, and a
// last query byte also hands off the result. After reset, and on every fifteenth clear,
// the transition memory is swept before in_tready rises. A finished result waits in the
// output register while new input is taken.
module suffix_automaton_lcs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  input  wire logic        in_tlast,   // last_query
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [9:0] match_start, [20:10] match_length,
                                       // [21] overflow, [23:22] zero
);

  sal_pkg::result_t res;
  logic             accept;
  logic             res_take;
  logic             ready;
  logic             out_valid_r;
  logic [23:0]      out_data_r;

  assign accept    = in_tvalid && ready;
  assign in_tready = ready;
  assign res_take  = res.valid && (!out_valid_r || out_tready);

  sal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_tuser),
    .data_byte (in_tdata),
    .last_query(in_tlast),
    .ready     (ready),
    .res       (res),
    .res_take  (res_take)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {2'b00, res.overflow, res.length, res.start};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### design/sal_ram.sv
`default_nettype none
// Simple dual-port memory: one write port, one registered read port.
module sal_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/sal_ctrl.sv
`default_nettype none
// Sequencer for automaton build and query matching over the shared tables.
module sal_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [1:0]                   opcode,
  input  wire logic [sal_pkg::SYM_W-1:0]    data_byte,
  input  wire logic                         last_query,
  output logic                              ready,
  output sal_pkg::result_t                  res,
  input  wire logic                         res_take
);

  localparam int NW = sal_pkg::NODE_W;
  localparam int LW = sal_pkg::LEN_W;
  localparam int TW = sal_pkg::TEXT_W;
  localparam int SW = sal_pkg::SYM_W;
  localparam int CW = sal_pkg::CNT_W;
  localparam int EW = sal_pkg::EPOCH_W;
  localparam int AW = sal_pkg::TR_ADDR_W;
  localparam int DW = sal_pkg::TR_DATA_W;
  localparam int RW = sal_pkg::ROW_CNT_W;

  sal_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [EW-1:0] epoch_r, epoch_nxt;
  logic [CW-1:0] node_cnt_r, node_cnt_nxt;
  logic [NW-1:0] last_r, last_nxt;
  logic [LW-1:0] last_len_r, last_len_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] cur_len_r, cur_len_nxt;
  logic [NW-1:0] p_r, p_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [NW-1:0] clone_r, clone_nxt;
  logic [LW-1:0] lenp_r, lenp_nxt;
  logic [RW-1:0] k_r, k_nxt;
  logic [SW-1:0] sym_r, sym_nxt;
  logic          lastq_r, lastq_nxt;
  logic [NW-1:0] mn_r, mn_nxt;
  logic [LW-1:0] run_r, run_nxt;
  logic [LW-1:0] best_r, best_nxt;
  logic [TW-1:0] bend_r, bend_nxt;
  logic [SW-1:0] bfirst_r, bfirst_nxt;
  logic [LW-1:0] qidx_r, qidx_nxt;
  logic          ovf_r, ovf_nxt;
  sal_pkg::result_t res_r, res_nxt;

  // Memory ports
  logic          tr_we;
  logic [AW-1:0] tr_waddr, tr_raddr;
  logic [DW-1:0] tr_wdata, tr_rdata;
  logic          ln_we;
  logic [NW-1:0] ln_waddr, ln_raddr;
  logic [LW-1:0] ln_wdata, ln_rdata;
  logic          lk_we;
  logic [NW-1:0] lk_waddr, lk_raddr;
  logic [NW-1:0] lk_wdata, lk_rdata;
  logic          qb_we;
  logic [TW-1:0] qb_waddr, qb_raddr;
  logic [SW-1:0] qb_wdata, qb_rdata;

  logic [NW-1:0] tr_val;
  logic          ln_zero_r;
  logic [LW-1:0] ln_val;
  logic          text_full;
  logic [LW-1:0] upd_best;
  logic [TW-1:0] upd_end;
  logic [SW-1:0] upd_first;

  sal_ram #(.ADDR_W(AW), .DATA_W(DW)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );
  sal_ram #(.ADDR_W(NW), .DATA_W(LW)) u_len (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(ln_raddr), .rdata(ln_rdata)
  );
  sal_ram #(.ADDR_W(NW), .DATA_W(NW)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );
  sal_ram #(.ADDR_W(TW), .DATA_W(SW)) u_qbuf (
    .clk(clk), .we(qb_we), .waddr(qb_waddr), .wdata(qb_wdata),
    .raddr(qb_raddr), .rdata(qb_rdata)
  );

  // An entry written in an older epoch reads as no transition
  assign tr_val = (tr_rdata[DW-1 -: EW] == epoch_r) ? tr_rdata[NW-1:0] : '0;
  // The root length is always zero
  assign ln_val = ln_zero_r ? '0 : ln_rdata;
  always_ff @(posedge clk) begin
    ln_zero_r <= (ln_raddr == '0);
  end

  assign text_full = (last_len_r >= LW'(sal_pkg::MAX_TEXT)) ||
                     (node_cnt_r >= CW'(sal_pkg::NODES - 1));
  assign ready = (state_r == sal_pkg::ST_IDLE);
  assign res   = res_r;

  // Best-match update for the current query position
  always_comb begin
    upd_best  = best_r;
    upd_end   = bend_r;
    upd_first = bfirst_r;
    if (run_r > best_r) begin
      upd_best  = run_r;
      upd_end   = qidx_r[TW-1:0];
      upd_first = qb_rdata;
    end else if ((run_r == best_r) && (run_r != '0) && (bfirst_r > qb_rdata)) begin
      upd_end   = qidx_r[TW-1:0];
      upd_first = qb_rdata;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sal_pkg::ST_SWEEP: begin
        if (sweep_r == '1) state_nxt = sal_pkg::ST_IDLE;
      end
      sal_pkg::ST_IDLE: begin
        if (accept) begin
          case (opcode)
            sal_pkg::OP_CLEAR: begin
              if (epoch_r == '1) state_nxt = sal_pkg::ST_SWEEP;
            end
            sal_pkg::OP_APPEND: begin
              if (!text_full) state_nxt = sal_pkg::ST_A_RD;
            end
            sal_pkg::OP_MATCH: begin
              if (!qidx_r[LW-1])   state_nxt = sal_pkg::ST_M_RD;
              else if (last_query) state_nxt = sal_pkg::ST_OUT;
            end
            default: state_nxt = sal_pkg::ST_IDLE;
          endcase
        end
      end
      sal_pkg::ST_A_RD: state_nxt = sal_pkg::ST_A_EV;
      sal_pkg::ST_A_EV: begin
        if (tr_val != '0)    state_nxt = sal_pkg::ST_A_LP;
        else if (p_r == '0)  state_nxt = sal_pkg::ST_IDLE;
        else                 state_nxt = sal_pkg::ST_A_LK;
      end
      sal_pkg::ST_A_LK:  state_nxt = sal_pkg::ST_A_RD;
      sal_pkg::ST_A_LP:  state_nxt = sal_pkg::ST_A_LQ;
      sal_pkg::ST_A_LQ:  state_nxt = sal_pkg::ST_A_CMP;
      sal_pkg::ST_A_CMP: begin
        if (lenp_r + LW'(1) == ln_val) state_nxt = sal_pkg::ST_IDLE;
        else                           state_nxt = sal_pkg::ST_A_CP;
      end
      sal_pkg::ST_A_CP: begin
        if (k_r[RW-1]) state_nxt = sal_pkg::ST_A_CLR;
      end
      sal_pkg::ST_A_CLR: state_nxt = sal_pkg::ST_A_CLW;
      sal_pkg::ST_A_CLW: state_nxt = sal_pkg::ST_A_RRD;
      sal_pkg::ST_A_RRD: state_nxt = sal_pkg::ST_A_REV;
      sal_pkg::ST_A_REV: begin
        if ((tr_val == q_r) && (p_r != '0)) state_nxt = sal_pkg::ST_A_RLK;
        else                                 state_nxt = sal_pkg::ST_A_FQ;
      end
      sal_pkg::ST_A_RLK: state_nxt = sal_pkg::ST_A_RRD;
      sal_pkg::ST_A_FQ:  state_nxt = sal_pkg::ST_A_FC;
      sal_pkg::ST_A_FC:  state_nxt = sal_pkg::ST_IDLE;
      sal_pkg::ST_M_RD:  state_nxt = sal_pkg::ST_M_EV;
      sal_pkg::ST_M_EV: begin
        if ((mn_r != '0) && (tr_val == '0)) state_nxt = sal_pkg::ST_M_LK;
        else                                 state_nxt = sal_pkg::ST_M_QRD;
      end
      sal_pkg::ST_M_LK:  state_nxt = sal_pkg::ST_M_LN;
      sal_pkg::ST_M_LN:  state_nxt = sal_pkg::ST_M_LW;
      sal_pkg::ST_M_LW:  state_nxt = sal_pkg::ST_M_RD;
      sal_pkg::ST_M_QRD: state_nxt = sal_pkg::ST_M_QEV;
      sal_pkg::ST_M_QEV: begin
        if (lastq_r) state_nxt = sal_pkg::ST_OUT;
        else         state_nxt = sal_pkg::ST_IDLE;
      end
      sal_pkg::ST_OUT: begin
        if (res_take) state_nxt = sal_pkg::ST_IDLE;
      end
      default: state_nxt = sal_pkg::ST_IDLE;
    endcase
  end

  // Memory port drive
  always_comb begin
    tr_we    = 1'b0;
    tr_waddr = {p_r, sym_r};
    tr_wdata = {epoch_r, cur_r};
    tr_raddr = {p_r, sym_r};
    ln_we    = 1'b0;
    ln_waddr = cur_r;
    ln_wdata = cur_len_r;
    ln_raddr = p_r;
    lk_we    = 1'b0;
    lk_waddr = cur_r;
    lk_wdata = '0;
    lk_raddr = p_r;
    qb_we    = 1'b0;
    qb_waddr = qidx_r[TW-1:0];
    qb_wdata = data_byte;
    qb_raddr = TW'(qidx_r[TW-1:0] + TW'(1) - run_r[TW-1:0]);
    case (state_r)
      sal_pkg::ST_SWEEP: begin
        tr_we    = 1'b1;
        tr_waddr = sweep_r;
        tr_wdata = '0;
      end
      sal_pkg::ST_IDLE: begin
        if (accept && (opcode == sal_pkg::OP_APPEND) && !text_full) begin
          ln_we    = 1'b1;
          ln_waddr = node_cnt_r[NW-1:0];
          ln_wdata = last_len_r + LW'(1);
        end
        if (accept && (opcode == sal_pkg::OP_MATCH) && !qidx_r[LW-1]) begin
          qb_we = 1'b1;
        end
      end
      sal_pkg::ST_A_EV: begin
        if (tr_val == '0) begin
          tr_we = 1'b1;
          if (p_r == '0) lk_we = 1'b1;
        end
      end
      sal_pkg::ST_A_LQ: ln_raddr = q_r;
      sal_pkg::ST_A_CMP: begin
        if (lenp_r + LW'(1) == ln_val) begin
          lk_we    = 1'b1;
          lk_wdata = q_r;
        end else begin
          ln_we    = 1'b1;
          ln_waddr = node_cnt_r[NW-1:0];
          ln_wdata = lenp_r + LW'(1);
        end
      end
      sal_pkg::ST_A_CP: begin
        // Read column k of q while writing column k-1 of the clone
        tr_raddr = {q_r, k_r[SW-1:0]};
        tr_we    = (k_r != '0);
        tr_waddr = {clone_r, SW'(k_r - RW'(1))};
        tr_wdata = {epoch_r, tr_val};
      end
      sal_pkg::ST_A_CLR: lk_raddr = q_r;
      sal_pkg::ST_A_CLW: begin
        lk_we    = 1'b1;
        lk_waddr = clone_r;
        lk_wdata = lk_rdata;
      end
      sal_pkg::ST_A_REV: begin
        if (tr_val == q_r) begin
          tr_we    = 1'b1;
          tr_wdata = {epoch_r, clone_r};
        end
      end
      sal_pkg::ST_A_FQ: begin
        lk_we    = 1'b1;
        lk_waddr = q_r;
        lk_wdata = clone_r;
      end
      sal_pkg::ST_A_FC: begin
        lk_we    = 1'b1;
        lk_wdata = clone_r;
      end
      sal_pkg::ST_M_RD: tr_raddr = {mn_r, sym_r};
      sal_pkg::ST_M_EV: lk_raddr = mn_r;
      sal_pkg::ST_M_LN: ln_raddr = mn_r;
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    sweep_nxt    = sweep_r;
    epoch_nxt    = epoch_r;
    node_cnt_nxt = node_cnt_r;
    last_nxt     = last_r;
    last_len_nxt = last_len_r;
    cur_nxt      = cur_r;
    cur_len_nxt  = cur_len_r;
    p_nxt        = p_r;
    q_nxt        = q_r;
    clone_nxt    = clone_r;
    lenp_nxt     = lenp_r;
    k_nxt        = k_r;
    sym_nxt      = sym_r;
    lastq_nxt    = lastq_r;
    mn_nxt       = mn_r;
    run_nxt      = run_r;
    best_nxt     = best_r;
    bend_nxt     = bend_r;
    bfirst_nxt   = bfirst_r;
    qidx_nxt     = qidx_r;
    ovf_nxt      = ovf_r;
    res_nxt      = res_r;
    case (state_r)
      sal_pkg::ST_SWEEP: begin
        sweep_nxt = sweep_r + AW'(1);
        epoch_nxt = EW'(1);
      end
      sal_pkg::ST_IDLE: begin
        if (accept) begin
          sym_nxt   = data_byte;
          lastq_nxt = last_query;
          case (opcode)
            sal_pkg::OP_CLEAR: begin
              node_cnt_nxt = CW'(1);
              last_nxt     = '0;
              last_len_nxt = '0;
              mn_nxt       = '0;
              run_nxt      = '0;
              best_nxt     = '0;
              bend_nxt     = '0;
              qidx_nxt     = '0;
              ovf_nxt      = 1'b0;
              sweep_nxt    = '0;
              epoch_nxt    = epoch_r + EW'(1);
            end
            sal_pkg::OP_APPEND: begin
              if (text_full) begin
                ovf_nxt = 1'b1;
              end else begin
                cur_nxt      = node_cnt_r[NW-1:0];
                cur_len_nxt  = last_len_r + LW'(1);
                node_cnt_nxt = node_cnt_r + CW'(1);
                p_nxt        = last_r;
              end
            end
            sal_pkg::OP_MATCH: begin
              if (qidx_r[LW-1]) begin
                ovf_nxt = 1'b1;
                if (last_query) begin
                  res_nxt.valid    = 1'b1;
                  res_nxt.start    = (best_r != '0) ?
                                     TW'({1'b0, bend_r} + LW'(1) - best_r) : '0;
                  res_nxt.length   = best_r;
                  res_nxt.overflow = 1'b1;
                  mn_nxt   = '0;
                  run_nxt  = '0;
                  best_nxt = '0;
                  bend_nxt = '0;
                  qidx_nxt = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      sal_pkg::ST_A_EV: begin
        if (tr_val != '0) begin
          q_nxt = tr_val;
        end else if (p_r == '0) begin
          last_nxt     = cur_r;
          last_len_nxt = cur_len_r;
        end
      end
      sal_pkg::ST_A_LK:  p_nxt = lk_rdata;
      sal_pkg::ST_A_LQ:  lenp_nxt = ln_val;
      sal_pkg::ST_A_CMP: begin
        if (lenp_r + LW'(1) == ln_val) begin
          last_nxt     = cur_r;
          last_len_nxt = cur_len_r;
        end else begin
          clone_nxt    = node_cnt_r[NW-1:0];
          node_cnt_nxt = node_cnt_r + CW'(1);
          k_nxt        = '0;
        end
      end
      sal_pkg::ST_A_CP:  k_nxt = k_r + RW'(1);
      sal_pkg::ST_A_RLK: p_nxt = lk_rdata;
      sal_pkg::ST_A_FC: begin
        last_nxt     = cur_r;
        last_len_nxt = cur_len_r;
      end
      sal_pkg::ST_M_EV: begin
        if (tr_val != '0) begin
          mn_nxt  = tr_val;
          run_nxt = run_r + LW'(1);
        end
      end
      sal_pkg::ST_M_LK: mn_nxt = lk_rdata;
      sal_pkg::ST_M_LW: run_nxt = ln_val;
      sal_pkg::ST_M_QEV: begin
        best_nxt   = upd_best;
        bend_nxt   = upd_end;
        bfirst_nxt = upd_first;
        qidx_nxt   = qidx_r + LW'(1);
        if (lastq_r) begin
          res_nxt.valid    = 1'b1;
          res_nxt.start    = (upd_best != '0) ?
                             TW'({1'b0, upd_end} + LW'(1) - upd_best) : '0;
          res_nxt.length   = upd_best;
          res_nxt.overflow = ovf_r;
          mn_nxt   = '0;
          run_nxt  = '0;
          best_nxt = '0;
          bend_nxt = '0;
          qidx_nxt = '0;
        end
      end
      sal_pkg::ST_OUT: begin
        if (res_take) res_nxt.valid = 1'b0;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sal_pkg::ST_SWEEP;
      sweep_r    <= '0;
      epoch_r    <= '0;
      node_cnt_r <= CW'(1);
      last_r     <= '0;
      last_len_r <= '0;
      mn_r       <= '0;
      run_r      <= '0;
      best_r     <= '0;
      bend_r     <= '0;
      qidx_r     <= '0;
      ovf_r      <= 1'b0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      epoch_r    <= epoch_nxt;
      node_cnt_r <= node_cnt_nxt;
      last_r     <= last_nxt;
      last_len_r <= last_len_nxt;
      mn_r       <= mn_nxt;
      run_r      <= run_nxt;
      best_r     <= best_nxt;
      bend_r     <= bend_nxt;
      qidx_r     <= qidx_nxt;
      ovf_r      <= ovf_nxt;
      res_r      <= res_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cur_len_r <= cur_len_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    clone_r   <= clone_nxt;
    lenp_r    <= lenp_nxt;
    k_r       <= k_nxt;
    sym_r     <= sym_nxt;
    lastq_r   <= lastq_nxt;
    bfirst_r  <= bfirst_nxt;
  end

endmodule
`default_nettype wire

### design/sal_checker.sv
`default_nettype none
`include "suffix_automaton_lcs_assert.svh"
// Port-level checks on the result channel.
module sal_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  `SAL_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `SAL_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")
  `SAL_ASSERT_NOW(a_empty_start, out_tvalid && (out_tdata[20:10] == 11'd0), out_tdata[9:0] == 10'd0, "nonzero start on empty match")
  `SAL_ASSERT_NOW(a_len_range, out_tvalid && out_tdata[20], (out_tdata[19:10] == 10'd0) && (out_tdata[23:22] == 2'd0), "match length or padding out of range")

endmodule

bind suffix_automaton_lcs sal_checker u_sal_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire

### verif/testbench.sv
`default_nettype none
module testbench;

  // Opcode that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int MAX_CLEARS = 12;

  typedef struct packed {
    logic [sal_pkg::TEXT_W-1:0] start;
    logic [sal_pkg::LEN_W-1:0]  length;
    logic                       overflow;
  } lcs_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  suffix_automaton_lcs dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Automaton mirror
  logic [sal_pkg::NODE_W-1:0] sam_next [0:sal_pkg::NODES-1][0:255];
  int                sam_len  [0:sal_pkg::NODES-1];
  int                sam_link [0:sal_pkg::NODES-1];
  int                sam_nodes;
  int                sam_last;
  // Matcher mirror
  int                mt_node;
  int                mt_run;
  int                mt_best_len;
  int                mt_best_end;
  logic [7:0]        mt_query [0:sal_pkg::MAX_TEXT-1];
  int                mt_index;
  logic              sticky_ovf;

  lcs_result_t pending_lcs [$];
  int idle_in;
  int idle_out;
  int mismatches;
  int results_seen;
  int items_sent;
  int clears_sent;
  int watchdog;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void reset_automaton();
    for (int s = 0; s < 256; s++) sam_next[0][s] = '0;
    sam_len[0] = 0;
    sam_link[0] = -1;
    sam_nodes = 1;
    sam_last = 0;
  endfunction

  function automatic void reset_matcher();
    mt_node = 0;
    mt_run = 0;
    mt_best_len = 0;
    mt_best_end = 0;
    mt_index = 0;
  endfunction

  // Extend the automaton by one symbol, splitting a state where needed
  function automatic void extend_text(int sym);
    int cur;
    int p;
    int q;
    int cln;
    if (sam_len[sam_last] >= sal_pkg::MAX_TEXT || sam_nodes + 2 > sal_pkg::NODES) begin
      sticky_ovf = 1'b1;
      return;
    end
    cur = sam_nodes++;
    sam_len[cur] = sam_len[sam_last] + 1;
    for (int s = 0; s < 256; s++) sam_next[cur][s] = '0;
    p = sam_last;
    while (p >= 0 && sam_next[p][sym] == 0) begin
      sam_next[p][sym] = sal_pkg::NODE_W'(cur);
      p = sam_link[p];
    end
    if (p < 0) begin
      sam_link[cur] = 0;
    end else begin
      q = int'(sam_next[p][sym]);
      if (sam_len[p] + 1 == sam_len[q]) begin
        sam_link[cur] = q;
      end else begin
        cln = sam_nodes++;
        sam_len[cln] = sam_len[p] + 1;
        for (int s = 0; s < 256; s++) sam_next[cln][s] = sam_next[q][s];
        sam_link[cln] = sam_link[q];
        while (p >= 0 && int'(sam_next[p][sym]) == q) begin
          sam_next[p][sym] = sal_pkg::NODE_W'(cln);
          p = sam_link[p];
        end
        sam_link[q] = cln;
        sam_link[cur] = cln;
      end
    end
    sam_last = cur;
  endfunction

  // Advance the matcher by one query byte and track the best run
  function automatic void advance_query(logic [7:0] b);
    int i;
    int lk;
    int kept;
    int cand;
    i = mt_index;
    if (i >= sal_pkg::MAX_TEXT) begin
      sticky_ovf = 1'b1;
      return;
    end
    mt_query[i] = b;
    while (mt_node != 0 && sam_next[mt_node][b] == 0) begin
      lk = sam_link[mt_node];
      mt_node = lk > 0 ? lk : 0;
      mt_run = sam_len[mt_node];
    end
    if (sam_next[mt_node][b] != 0) begin
      mt_node = int'(sam_next[mt_node][b]);
      mt_run++;
    end
    if (mt_run > mt_best_len) begin
      mt_best_len = mt_run;
      mt_best_end = i;
    end else if (mt_run == mt_best_len && mt_run != 0) begin
      kept = (mt_best_end + 1 - mt_best_len) % sal_pkg::MAX_TEXT;
      cand = (i + 1 - mt_run) % sal_pkg::MAX_TEXT;
      if (mt_query[kept] > mt_query[cand]) mt_best_end = i;
    end
    mt_index = i + 1;
  endfunction

  function automatic void predict_lcs(logic [1:0] op, logic [7:0] b, logic lst);
    lcs_result_t r;
    case (op)
      sal_pkg::OP_CLEAR: begin
        reset_automaton();
        reset_matcher();
        sticky_ovf = 1'b0;
      end
      sal_pkg::OP_APPEND: extend_text(int'(b));
      sal_pkg::OP_MATCH: begin
        advance_query(b);
        if (lst) begin
          r.start = mt_best_len != 0 ?
                    sal_pkg::TEXT_W'(mt_best_end + 1 - mt_best_len) : '0;
          r.length = sal_pkg::LEN_W'(mt_best_len);
          r.overflow = sticky_ovf;
          pending_lcs.push_back(r);
          reset_matcher();
        end
      end
      default: ;
    endcase
  endfunction

  // Send one transaction, idling at random beforehand
  task automatic send_item(logic [1:0] op, logic [7:0] b, logic lst);
    while ($urandom_range(99) < idle_in) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = b;
    in_tlast = lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_lcs(op, b, lst);
    if (op != OP_UNUSED) items_sent++;
    if (op == sal_pkg::OP_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_lcs.size() != 0) @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_item(sal_pkg::OP_APPEND, s[k], 1'b0);
  endtask

  task automatic send_query(string s);
    for (int k = 0; k < s.len(); k++) send_item(sal_pkg::OP_MATCH, s[k], k == s.len() - 1);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= idle_out);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    lcs_result_t exp_r;
    lcs_result_t act_r;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      act_r.start = out_tdata[9:0];
      act_r.length = out_tdata[20:10];
      act_r.overflow = out_tdata[21];
      if (pending_lcs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = pending_lcs.pop_front();
        if (exp_r !== act_r || out_tdata[23:22] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp start %0d len %0d ovf %0d, got start %0d len %0d ovf %0d",
                     exp_r.start, exp_r.length, exp_r.overflow,
                     act_r.start, act_r.length, act_r.overflow);
        end
      end
    end
  end

  // Abort when nothing moves for too long (covers the memory sweep)
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("suffix_automaton_lcs test failed");
      $finish;
    end
  end

  task automatic test_directed();
    // Empty automaton: no match, start zero
    send_query("xy");
    send_text("banana");
    send_query("ananas");
    // Equal lengths: later run with smaller first byte wins
    send_query("bxa");
    send_query("axb");
    // Byte extremes and the unused opcode
    send_item(sal_pkg::OP_APPEND, 8'h00, 1'b0);
    send_item(sal_pkg::OP_APPEND, 8'hff, 1'b1);
    send_item(OP_UNUSED, 8'hff, 1'b1);
    send_item(sal_pkg::OP_MATCH, 8'hff, 1'b0);
    send_item(sal_pkg::OP_MATCH, 8'h00, 1'b0);
    send_item(sal_pkg::OP_MATCH, 8'hff, 1'b1);
    drain_results();
    send_item(sal_pkg::OP_CLEAR, 8'h00, 1'b0);
    send_query("a");
    drain_results();
  endtask

  task automatic test_random(int n_items);
    int goal;
    int tlen;
    int qlen;
    int span;
    logic [7:0] b;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if (clears_sent < MAX_CLEARS && $urandom_range(9) == 0)
        send_item(sal_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
      span = $urandom_range(3) == 0 ? 255 : $urandom_range(1, 3);
      tlen = $urandom_range(0, 12);
      for (int k = 0; k < tlen; k++) begin
        b = span == 255 ? 8'($urandom) : 8'(97 + $urandom_range(span));
        send_item(sal_pkg::OP_APPEND, b, 1'($urandom));
      end
      for (int qn = $urandom_range(1, 3); qn > 0; qn--) begin
        qlen = $urandom_range(1, 10);
        for (int k = 0; k < qlen; k++) begin
          b = span == 255 ? 8'($urandom) : 8'(97 + $urandom_range(span));
          if ($urandom_range(19) == 0) send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
          send_item(sal_pkg::OP_MATCH, b, k == qlen - 1);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = sal_pkg::OP_CLEAR;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    items_sent = 0;
    clears_sent = 0;
    idle_in = 37;
    idle_out = 45;
    reset_automaton();
    reset_matcher();
    sticky_ovf = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(300);
    idle_in = 45;
    idle_out = 37;
    test_random(300);
    idle_in = 0;
    idle_out = 0;
    test_random(300);

    drain_results();
    repeat (400) @(negedge clk);
    $display("Covered %0d input items and %0d results, including empty matches,",
             items_sent, results_seen);
    $display("tie-breaks, ignored opcodes and %0d clears under three stall mixes.", clears_sent);
    if (mismatches == 0 && pending_lcs.size() == 0) begin
      $display("suffix_automaton_lcs test passed");
    end else begin
      $display("suffix_automaton_lcs test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### suffix_automaton_lcs.f
+incdir+design
design/sal_pkg.sv
design/sal_ram.sv
design/sal_ctrl.sv
design/suffix_automaton_lcs.sv
design/sal_checker.sv
verif/testbench.sv
